>>> src/tkst_pkg.sv
`default_nettype none

package tkst_pkg;

   // Table geometry.
   localparam int DEPTH      = 16;
   localparam int IDX_W      = $clog2(DEPTH);
   localparam int CNT_W      = $clog2(DEPTH + 1);
   localparam int RANK_W     = 4;
   localparam int MAX_OUT    = 16;
   localparam int DUMP_LIMIT = (DEPTH < MAX_OUT) ? DEPTH : MAX_OUT;

   // Field widths.
   localparam int OP_W    = 2;
   localparam int ID_W    = 32;
   localparam int SCORE_W = 32;

   // Operation codes.
   localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
   localparam logic [OP_W-1:0] OP_DUMP   = 2'd1;
   localparam logic [OP_W-1:0] OP_LOOKUP = 2'd2;

   typedef logic [OP_W-1:0]           op_type;
   typedef logic [ID_W-1:0]           id_type;
   typedef logic signed [SCORE_W-1:0] score_type;
   typedef logic [IDX_W-1:0]          idx_type;
   typedef logic [CNT_W-1:0]          cnt_type;
   typedef logic [RANK_W-1:0]         rank_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic latch_req;
      logic do_insert;
      logic emit_lookup;
      logic emit_dump;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      op_type op;
      logic   out_free;
      logic   dump_last;
   } status_type;

   // True when (score_a, id_a) ranks strictly above (score_b, id_b).
   function automatic logic ranks_above(score_type score_a, id_type id_a,
                                        score_type score_b, id_type id_b);
      logic result;
      if (score_a != score_b) begin
         result = score_a > score_b;
      end else begin
         result = id_a > id_b;
      end
      return result;
   endfunction

   // Rank as reported: the low bits of the table position.
   function automatic rank_type rank_of(idx_type idx);
      return RANK_W'(idx);
   endfunction

endpackage

`default_nettype wire

>>> src/tkst_ifs.sv
`default_nettype none

interface tkst_req_if import tkst_pkg::*; ();
   logic      valid;
   logic      ready;
   op_type    operation;
   id_type    player_id;
   score_type score;

   modport source (output valid, output operation, output player_id, output score,
                   input ready);
   modport sink (input valid, input operation, input player_id, input score,
                 output ready);
endinterface

interface tkst_rsp_if import tkst_pkg::*; ();
   logic      valid;
   logic      ready;
   id_type    out_id;
   score_type out_score;
   rank_type  rank;
   logic      found;
   logic      last;

   modport source (output valid, output out_id, output out_score, output rank,
                   output found, output last, input ready);
   modport sink (input valid, input out_id, input out_score, input rank,
                 input found, input last, output ready);
endinterface

`default_nettype wire

>>> src/tkst_dpath.sv
`default_nettype none

module tkst_dpath import tkst_pkg::*; (
   input  wire        clock,
   input  wire        reset,
   input  cmd_type    cmd,
   output status_type status,
   input  op_type     req_operation,
   input  id_type     req_player_id,
   input  score_type  req_score,
   output logic       rsp_valid,
   input  wire        rsp_ready,
   output id_type     rsp_out_id,
   output score_type  rsp_out_score,
   output rank_type   rsp_rank,
   output logic       rsp_found,
   output logic       rsp_last
);

   // Latched request.
   op_type    op_ff;
   id_type    qid_ff;
   score_type qscore_ff;

   // Ranked table, highest at index 0.
   score_type tab_score_ff [DEPTH];
   id_type    tab_id_ff    [DEPTH];
   score_type tab_score_in [DEPTH];
   id_type    tab_id_in    [DEPTH];
   logic      tab_we;

   cnt_type fill_ff, fill_in;
   idx_type dump_idx_ff, dump_idx_in;

   // Output word register.
   logic      out_valid_ff, out_valid_in;
   id_type    out_id_ff, out_id_in;
   score_type out_score_ff, out_score_in;
   rank_type  out_rank_ff, out_rank_in;
   logic      out_found_ff, out_found_in;
   logic      out_last_ff, out_last_in;
   logic      out_load;

   logic       full, take_full;
   cnt_type    n_eff;
   logic [DEPTH-1:0] above;
   logic       hit_any;
   idx_type    hit_idx;
   idx_type    rd_idx;
   score_type  rd_score;
   id_type     rd_id;
   cnt_type    dump_cnt;
   logic       table_empty;
   logic       dump_last;
   logic       out_free;

   always_ff @(posedge clock) begin
      if (cmd.latch_req) begin
         op_ff     <= req_operation;
         qid_ff    <= req_player_id;
         qscore_ff <= req_score;
      end
   end

   // Insertion: every slot compares the new entry against itself at once.
   always_comb begin
      full      = (fill_ff == CNT_W'(DEPTH));
      take_full = qscore_ff > tab_score_ff[DEPTH-1];
      n_eff     = full ? CNT_W'(DEPTH - 1) : fill_ff;
      tab_we    = cmd.do_insert && (!full || take_full);
      for (int i = 0; i < DEPTH; i++) begin
         above[i] = (CNT_W'(i) < n_eff)
                    && ranks_above(qscore_ff, qid_ff, tab_score_ff[i], tab_id_ff[i]);
      end
      for (int i = 0; i < DEPTH; i++) begin
         if (i > 0 && above[(i > 0) ? i - 1 : 0]) begin
            tab_score_in[i] = tab_score_ff[(i > 0) ? i - 1 : 0];
            tab_id_in[i]    = tab_id_ff[(i > 0) ? i - 1 : 0];
         end else if (above[i] || CNT_W'(i) == n_eff) begin
            tab_score_in[i] = qscore_ff;
            tab_id_in[i]    = qid_ff;
         end else begin
            tab_score_in[i] = tab_score_ff[i];
            tab_id_in[i]    = tab_id_ff[i];
         end
      end
      fill_in = (tab_we && !full) ? fill_ff + CNT_W'(1) : fill_ff;
   end

   always_ff @(posedge clock) begin
      if (tab_we) begin
         for (int i = 0; i < DEPTH; i++) begin
            tab_score_ff[i] <= tab_score_in[i];
            tab_id_ff[i]    <= tab_id_in[i];
         end
      end
   end

   // Lookup: the highest-ranked matching slot wins.
   always_comb begin
      hit_any = 1'b0;
      hit_idx = '0;
      for (int i = DEPTH - 1; i >= 0; i--) begin
         if (CNT_W'(i) < fill_ff && tab_id_ff[i] == qid_ff) begin
            hit_any = 1'b1;
            hit_idx = IDX_W'(i);
         end
      end
   end

   // One shared read port for lookup and dump.
   always_comb begin
      rd_idx      = cmd.emit_lookup ? hit_idx : dump_idx_ff;
      rd_score    = tab_score_ff[rd_idx];
      rd_id       = tab_id_ff[rd_idx];
      dump_cnt    = (fill_ff < CNT_W'(DUMP_LIMIT)) ? fill_ff : CNT_W'(DUMP_LIMIT);
      table_empty = (fill_ff == '0);
      dump_last   = table_empty || (CNT_W'(dump_idx_ff) + CNT_W'(1) == dump_cnt);
      out_free    = !out_valid_ff || rsp_ready;
      out_load    = cmd.emit_lookup || cmd.emit_dump;
   end

   always_comb begin
      out_id_in    = out_id_ff;
      out_score_in = out_score_ff;
      out_rank_in  = out_rank_ff;
      out_found_in = out_found_ff;
      out_last_in  = out_last_ff;
      if (cmd.emit_lookup) begin
         out_id_in    = hit_any ? rd_id : qid_ff;
         out_score_in = hit_any ? rd_score : '0;
         out_rank_in  = hit_any ? rank_of(hit_idx) : '0;
         out_found_in = hit_any;
         out_last_in  = 1'b1;
      end else if (cmd.emit_dump) begin
         out_id_in    = table_empty ? '0 : rd_id;
         out_score_in = table_empty ? '0 : rd_score;
         out_rank_in  = table_empty ? '0 : rank_of(dump_idx_ff);
         out_found_in = !table_empty;
         out_last_in  = dump_last;
      end
      out_valid_in = out_load || (out_valid_ff && !rsp_ready);
      if (cmd.latch_req) begin
         dump_idx_in = '0;
      end else if (cmd.emit_dump) begin
         dump_idx_in = dump_idx_ff + IDX_W'(1);
      end else begin
         dump_idx_in = dump_idx_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff      <= '0;
         out_valid_ff <= 1'b0;
         dump_idx_ff  <= '0;
      end else begin
         fill_ff      <= fill_in;
         out_valid_ff <= out_valid_in;
         dump_idx_ff  <= dump_idx_in;
      end
   end

   always_ff @(posedge clock) begin
      out_id_ff    <= out_id_in;
      out_score_ff <= out_score_in;
      out_rank_ff  <= out_rank_in;
      out_found_ff <= out_found_in;
      out_last_ff  <= out_last_in;
   end

   assign status.op        = op_ff;
   assign status.out_free  = out_free;
   assign status.dump_last = dump_last;

   assign rsp_valid     = out_valid_ff;
   assign rsp_out_id    = out_id_ff;
   assign rsp_out_score = out_score_ff;
   assign rsp_rank      = out_rank_ff;
   assign rsp_found     = out_found_ff;
   assign rsp_last      = out_last_ff;

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= CNT_W'(DEPTH))
      else $error("fill count beyond table depth");

   a_fill_grows: assert property (@(posedge clock) disable iff (reset)
      (cmd.do_insert && !full) |=> (fill_ff == $past(fill_ff) + CNT_W'(1)))
      else $error("insert into a non-full table did not grow it");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      out_load |-> out_free)
      else $error("output word loaded while the previous one is still held");

endmodule

`default_nettype wire

>>> src/tkst_ctrl.sv
`default_nettype none

module tkst_ctrl import tkst_pkg::*; (
   input  wire        clock,
   input  wire        reset,
   input  wire        req_valid,
   output logic       req_ready,
   input  status_type status,
   output cmd_type    cmd
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_EXEC = 2'd1;
   localparam logic [1:0] ST_DUMP = 2'd2;

   logic [1:0] state_ff, state_in;

   always_comb begin
      state_in        = state_ff;
      req_ready       = 1'b0;
      cmd.latch_req   = 1'b0;
      cmd.do_insert   = 1'b0;
      cmd.emit_lookup = 1'b0;
      cmd.emit_dump   = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready     = 1'b1;
            cmd.latch_req = req_valid;
            if (req_valid) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            case (status.op)
               OP_INSERT: begin
                  cmd.do_insert = 1'b1;
                  state_in      = ST_IDLE;
               end
               OP_DUMP: begin
                  state_in = ST_DUMP;
               end
               OP_LOOKUP: begin
                  if (status.out_free) begin
                     cmd.emit_lookup = 1'b1;
                     state_in        = ST_IDLE;
                  end
               end
               default: begin
                  state_in = ST_IDLE;
               end
            endcase
         end
         ST_DUMP: begin
            if (status.out_free) begin
               cmd.emit_dump = 1'b1;
               if (status.dump_last) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   a_dump_ends: assert property (@(posedge clock) disable iff (reset)
      (cmd.emit_dump && status.dump_last) |=> (state_ff == ST_IDLE))
      else $error("dump did not finish after its last word");

   a_accept_exec: assert property (@(posedge clock) disable iff (reset)
      cmd.latch_req |=> (state_ff == ST_EXEC))
      else $error("accepted request not executed");

   a_one_cmd: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.latch_req, cmd.do_insert, cmd.emit_lookup, cmd.emit_dump}))
      else $error("more than one command issued in a cycle");

endmodule

`default_nettype wire

>>> src/top_k_score_table_unit.sv
`default_nettype none

// Ranked score table holding up to DEPTH (player id, score) entries, kept in
// order of score and then id, highest first.
// Requests arrive on the req channel and results leave on the rsp channel;
// both use a valid/ready handshake, and a word moves at a clock edge where
// valid and ready are both high.
// An insert gives no word: the request is accepted in the idle state, and
// then in the execute state every slot compares itself with the new entry in
// parallel and the table shifts down below the insertion point.
// A lookup compares all stored ids in parallel and loads its single word
// into the output register in the execute state once that register is free;
// the controller then returns to idle, ready for the next request.
// A dump streams the entries from the top, at most sixteen of them, in the
// dump state, one word per cycle while the receiver takes them, marking the
// final word with last. An empty table dumps one word with found low.
// Requests are handled one at a time; the output register lets a new request
// be accepted while the last word is still waiting to be taken.
// When the receiver stalls, the word is held and the dump pauses.
// Synchronous reset empties the table; no clearing pass is needed because
// entries beyond the fill count are never read.

module top_k_score_table_unit import tkst_pkg::*; (
   input  wire      clock,
   input  wire      reset,
   tkst_req_if.sink   req,
   tkst_rsp_if.source rsp
);

   cmd_type    cmd;
   status_type status;
   logic       req_ready;

   tkst_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   tkst_dpath u_dpath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .status        (status),
      .req_operation (req.operation),
      .req_player_id (req.player_id),
      .req_score     (req.score),
      .rsp_valid     (rsp.valid),
      .rsp_ready     (rsp.ready),
      .rsp_out_id    (rsp.out_id),
      .rsp_out_score (rsp.out_score),
      .rsp_rank      (rsp.rank),
      .rsp_found     (rsp.found),
      .rsp_last      (rsp.last)
   );

   assign req.ready = req_ready;

endmodule

`default_nettype wire
